[src/i2cbcm_pkg.sv]
// package: shared types, constants and phase encoding for the i2c byte command master
package i2cbcm_pkg;

   localparam int QueueDepth = 1024;
   localparam int QAddrW = $clog2(QueueDepth);
   localparam int QCountW = QAddrW + 1;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_NACK    = 3'd1;
   localparam logic [2:0] ERR_TIMEOUT = 3'd2;
   localparam logic [2:0] ERR_FULL    = 3'd3;
   localparam logic [2:0] ERR_EMPTY   = 3'd4;
   localparam logic [2:0] ERR_FAILED  = 3'd5;

   localparam logic [0:0] REG_HALF    = 1'd0;
   localparam logic [0:0] REG_STRETCH = 1'd1;

   typedef enum logic [4:0] {
      PH_IDLE, PH_DELAY, PH_WAIT, PH_START_REL, PH_START_SDA, PH_START_SCL,
      PH_WB_BIT, PH_WB_RISE, PH_WB_FALL, PH_WB_ACKREL, PH_WB_ACKRISE,
      PH_WB_ACKSAMP, PH_FLUSH, PH_STOP_SCL, PH_STOP_SDA, PH_STOP_RISE,
      PH_STOP_END, PH_RB_REL, PH_RB_RISE, PH_RB_SAMP, PH_RB_ACK,
      PH_RB_ACKRISE, PH_RB_END
   } phase_type;

   typedef enum logic [1:0] {K_START, K_STOP, K_READ} kind_type;

   typedef struct packed {
      logic       req_type;
      logic       do_start;
      logic       do_stop;
      logic       do_write;
      logic       do_read;
      logic       send_nack;
      logic [7:0] data_byte;
      logic       scl_level;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic       acked;
      logic [2:0] error_kind;
      logic [7:0] read_data;
   } rsp_type;

   // both item types are 16 bits wide, so one queue width fits either
   localparam int ItemW = $bits(req_type);

endpackage

[src/i2c_byte_command_master_unit.sv]
// top level: i2c byte command master with queue ports and csr port
// Items enter on req_ and one result leaves per item on rsp_. A command item
// (req_type 0) acts only while the master is idle; a tick item (req_type 1)
// advances the SCL/SDA line sequence by one step, so ticks should arrive every
// cycle as the timebase. Accepted items wait in a two-entry input queue; the
// engine takes the oldest one per clock cycle whenever the two-entry result
// queue has room, so items can follow back to back. An item is registered in
// the input queue and its result in the result queue. req_full rises when the
// input queue holds two items, which only happens while results are not popped.
// Bytes from write commands sit in a 1024-entry memory and go out when a stop
// or read flushes them; the next byte is prefetched, so a flush costs no extra
// tick. Registers: 0x0 half_period_ticks, 0x4 stretch_limit, which the user
// must write only while idle; the block itself does not enforce this.
module i2c_byte_command_master_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  i2cbcm_pkg::req_type req_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output i2cbcm_pkg::rsp_type rsp_item,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import i2cbcm_pkg::*;

   logic [15:0] half_ff, stretch_ff;
   logic        eng_take, fq_empty, res_valid, stall, q_full;
   req_type     fq_item;
   rsp_type     res;

   // csr registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= 16'd500;
         stretch_ff <= 16'd1000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_HALF) half_ff <= csr_pwdata[15:0];
         else                          stretch_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = {16'd0, (csr_paddr[2] == REG_STRETCH) ? stretch_ff : half_ff};

   // front side: input queue between the sender and the engine
   i2cbcm_fifo u_req_q (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full), .wdata(req_item),
      .pop(eng_take), .empty(fq_empty), .rdata(fq_item)
   );

   // back side: engine takes the oldest item when the result queue has room
   assign eng_take = !fq_empty && !q_full && !stall;

   i2cbcm_engine u_engine (
      .clock(clock), .reset(reset), .item_valid(eng_take), .item(fq_item),
      .half_period(half_ff), .stretch_lim(stretch_ff), .stall(stall),
      .res_valid(res_valid), .res(res)
   );

   i2cbcm_fifo u_rsp_q (
      .clock(clock), .reset(reset), .push(res_valid), .full(q_full), .wdata(res),
      .pop(rsp_pop), .empty(rsp_empty), .rdata(rsp_item)
   );

   assert property (@(posedge clock) disable iff (reset) eng_take |-> res_valid)
      else $error("taken item produced no result");
   assert property (@(posedge clock) disable iff (reset) !(res_valid && q_full))
      else $error("result pushed into full queue");
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result vanished");
endmodule

[src/i2cbcm_fifo.sv]
// fifo: small two-entry queue used between front and back and on the result side
module i2cbcm_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [i2cbcm_pkg::ItemW-1:0] wdata,
   input  logic                         pop,
   output logic                         empty,
   output logic [i2cbcm_pkg::ItemW-1:0] rdata
);
   import i2cbcm_pkg::*;

   logic [ItemW-1:0] mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= wdata;
   end
endmodule

[src/i2cbcm_engine.sv]
// engine: line sequencer, write queue memory and status generation, one item per cycle
module i2cbcm_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  i2cbcm_pkg::req_type item,
   input  logic [15:0]         half_period,
   input  logic [15:0]         stretch_lim,
   output logic                stall,
   output logic                res_valid,
   output i2cbcm_pkg::rsp_type res
);
   import i2cbcm_pkg::*;

   logic [7:0]         queue_mem [QueueDepth];
   logic [7:0]         qrd_ff;
   phase_type          phase_ff, phase_in, after_d_ff, after_d_in, after_w_ff, after_w_in;
   kind_type           kind_ff, kind_in;
   logic [QCountW-1:0] qcount_ff, qcount_in, fidx_ff, fidx_in;
   logic [7:0]         shift_ff, shift_in;
   logic [3:0]         bits_ff, bits_in;
   logic [15:0]        dcnt_ff, dcnt_in, scnt_ff, scnt_in;
   logic               scl_ff, scl_in, sda_ff, sda_in, failed_ff, failed_in;
   logic               nack_ff, nack_in;
   logic               qwr;
   logic               done;
   logic               ack_v;
   logic [2:0]         err_v;
   logic [7:0]         rd_v;
   logic [15:0]        hp, sl;

   // every item is finished in its own cycle; the queue byte at the flush index is prefetched
   assign stall = 1'b0;
   assign hp = (half_period == 16'd0) ? 16'd1 : half_period;
   assign sl = (stretch_lim == 16'd0) ? 16'd1 : stretch_lim;

   always_comb begin
      phase_in = phase_ff; after_d_in = after_d_ff; after_w_in = after_w_ff;
      kind_in = kind_ff; qcount_in = qcount_ff; fidx_in = fidx_ff;
      shift_in = shift_ff; bits_in = bits_ff; dcnt_in = dcnt_ff; scnt_in = scnt_ff;
      scl_in = scl_ff; sda_in = sda_ff; failed_in = failed_ff; nack_in = nack_ff;
      qwr = 1'b0; done = 1'b0; ack_v = 1'b0; err_v = ERR_NONE; rd_v = 8'd0;
      if (item_valid && item.req_type) begin
         case (phase_ff)
            PH_IDLE: ;
            PH_DELAY: begin
               dcnt_in = dcnt_ff + 16'd1;
               if (dcnt_in >= hp) phase_in = after_d_ff;
            end
            PH_WAIT: begin
               if (item.scl_level) begin
                  dcnt_in = '0; after_d_in = after_w_ff; phase_in = PH_DELAY;
               end else begin
                  scnt_in = scnt_ff + 16'd1;
                  if (scnt_in >= sl) begin
                     failed_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
                     qcount_in = '0; fidx_in = '0; done = 1'b1; err_v = ERR_TIMEOUT;
                     phase_in = PH_IDLE;
                  end else begin
                     dcnt_in = '0; after_d_in = PH_WAIT; phase_in = PH_DELAY;
                  end
               end
            end
            PH_START_REL: begin
               scl_in = 1'b0; sda_in = 1'b0; scnt_in = '0;
               after_w_in = PH_START_SDA; phase_in = PH_WAIT;
            end
            PH_START_SDA: begin
               sda_in = 1'b1; dcnt_in = '0; after_d_in = PH_START_SCL; phase_in = PH_DELAY;
            end
            PH_START_SCL: begin
               scl_in = 1'b1; bits_in = '0; phase_in = PH_WB_BIT;
            end
            PH_WB_BIT: begin
               sda_in = !shift_ff[7]; dcnt_in = '0; after_d_in = PH_WB_RISE;
               phase_in = PH_DELAY;
            end
            PH_WB_RISE, PH_WB_ACKRISE, PH_STOP_RISE, PH_RB_RISE, PH_RB_ACKRISE: begin
               scl_in = 1'b0; scnt_in = '0; phase_in = PH_WAIT;
               case (phase_ff)
                  PH_WB_RISE:    after_w_in = PH_WB_FALL;
                  PH_WB_ACKRISE: after_w_in = PH_WB_ACKSAMP;
                  PH_STOP_RISE:  after_w_in = PH_STOP_END;
                  PH_RB_RISE:    after_w_in = PH_RB_SAMP;
                  default:       after_w_in = PH_RB_END;
               endcase
            end
            PH_WB_FALL: begin
               scl_in = 1'b1; shift_in = {shift_ff[6:0], 1'b0}; bits_in = bits_ff + 4'd1;
               phase_in = (bits_in >= 4'd8) ? PH_WB_ACKREL : PH_WB_BIT;
            end
            PH_WB_ACKREL: begin
               sda_in = 1'b0; dcnt_in = '0; after_d_in = PH_WB_ACKRISE; phase_in = PH_DELAY;
            end
            PH_WB_ACKSAMP: begin
               scl_in = 1'b1;
               if (kind_ff == K_START) begin
                  done = 1'b1; ack_v = !item.sda_level; phase_in = PH_IDLE;
               end else if (item.sda_level) begin
                  failed_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
                  qcount_in = '0; fidx_in = '0; done = 1'b1; err_v = ERR_NACK;
                  phase_in = PH_IDLE;
               end else phase_in = PH_FLUSH;
            end
            PH_FLUSH: begin
               if (fidx_ff < qcount_ff) begin
                  shift_in = qrd_ff; fidx_in = fidx_ff + QCountW'(1); bits_in = '0;
                  phase_in = PH_WB_BIT;
               end else begin
                  qcount_in = '0; fidx_in = '0;
                  phase_in = (kind_ff == K_STOP) ? PH_STOP_SCL : PH_RB_REL;
               end
            end
            PH_STOP_SCL: begin scl_in = 1'b1; phase_in = PH_STOP_SDA; end
            PH_STOP_SDA: begin
               sda_in = 1'b1; dcnt_in = '0; after_d_in = PH_STOP_RISE; phase_in = PH_DELAY;
            end
            PH_STOP_END: begin
               sda_in = 1'b0; done = 1'b1; ack_v = 1'b1; phase_in = PH_IDLE;
            end
            PH_RB_REL: begin
               sda_in = 1'b0; shift_in = '0; bits_in = '0; dcnt_in = '0;
               after_d_in = PH_RB_RISE; phase_in = PH_DELAY;
            end
            PH_RB_SAMP: begin
               shift_in = {shift_ff[6:0], item.sda_level}; scl_in = 1'b1;
               bits_in = bits_ff + 4'd1;
               if (bits_in >= 4'd8) phase_in = PH_RB_ACK;
               else begin dcnt_in = '0; after_d_in = PH_RB_RISE; phase_in = PH_DELAY; end
            end
            PH_RB_ACK: begin
               sda_in = !nack_ff; dcnt_in = '0; after_d_in = PH_RB_ACKRISE;
               phase_in = PH_DELAY;
            end
            PH_RB_END: begin
               scl_in = 1'b1; rd_v = shift_ff; done = 1'b1; ack_v = 1'b1; phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (item_valid && phase_ff == PH_IDLE) begin
         if (failed_ff) begin
            done = 1'b1; err_v = ERR_FAILED;
         end else if (item.do_start) begin
            kind_in = K_START; shift_in = item.data_byte; phase_in = PH_START_REL;
         end else if (item.do_stop) begin
            kind_in = K_STOP; fidx_in = '0; phase_in = PH_FLUSH;
         end else if (item.do_write) begin
            done = 1'b1;
            if (qcount_ff >= QCountW'(QueueDepth)) err_v = ERR_FULL;
            else begin
               qwr = 1'b1; qcount_in = qcount_ff + QCountW'(1); ack_v = 1'b1;
            end
         end else if (item.do_read) begin
            kind_in = K_READ; nack_in = item.send_nack; fidx_in = '0; phase_in = PH_FLUSH;
         end else begin
            done = 1'b1; err_v = ERR_EMPTY;
         end
      end
   end

   // the result shows the line state after this item
   always_comb begin
      res_valid        = item_valid;
      res.scl_pull_low = scl_in;
      res.sda_pull_low = sda_in;
      res.busy_res     = (phase_in != PH_IDLE);
      res.done_res     = done;
      res.acked        = ack_v;
      res.error_kind   = err_v;
      res.read_data    = rd_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; after_d_ff <= PH_IDLE; after_w_ff <= PH_IDLE;
         kind_ff <= K_START; qcount_ff <= '0; fidx_ff <= '0; shift_ff <= '0;
         bits_ff <= '0; dcnt_ff <= '0; scnt_ff <= '0; scl_ff <= 1'b0; sda_ff <= 1'b0;
         failed_ff <= 1'b0; nack_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; after_d_ff <= after_d_in; after_w_ff <= after_w_in;
         kind_ff <= kind_in; qcount_ff <= qcount_in; fidx_ff <= fidx_in; shift_ff <= shift_in;
         bits_ff <= bits_in; dcnt_ff <= dcnt_in; scnt_ff <= scnt_in; scl_ff <= scl_in;
         sda_ff <= sda_in; failed_ff <= failed_in; nack_ff <= nack_in;
      end
      if (qwr) queue_mem[qcount_ff[QAddrW-1:0]] <= item.data_byte;
      // prefetch the byte at the next flush index
      qrd_ff <= queue_mem[fidx_in[QAddrW-1:0]];
   end

   assert property (@(posedge clock) disable iff (reset) failed_ff |=> failed_ff)
      else $error("failed state cleared without reset");
   assert property (@(posedge clock) disable iff (reset) qcount_ff <= QCountW'(QueueDepth))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset) done |=> phase_ff == PH_IDLE)
      else $error("done without returning idle");
endmodule

[tb/testbench.sv]
// testbench: i2c byte command master checked item by item against a local line-sequence predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cbcm_pkg::*;

   // ---------------------------------------------------------------------------
   // status scoreboard: expected results in order, compared field by field
   // ---------------------------------------------------------------------------
   class status_scoreboard;
      rsp_type waiting_q[$];
      int      fail_count;

      function void note_item(rsp_type r);
         waiting_q.push_back(r);
      endfunction

      function void cmp_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $realtime, name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (waiting_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
            fail_count++;
            return;
         end
         want = waiting_q.pop_front();
         cmp_field("scl_pull_low", want.scl_pull_low, got.scl_pull_low);
         cmp_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
         cmp_field("busy_res", want.busy_res, got.busy_res);
         cmp_field("done_res", want.done_res, got.done_res);
         cmp_field("acked", want.acked, got.acked);
         cmp_field("error_kind", want.error_kind, got.error_kind);
         cmp_field("read_data", want.read_data, got.read_data);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, reset and block ports
   // ---------------------------------------------------------------------------
   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   req_type     req_item = '0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   rsp_type     rsp_item;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #5 clock = ~clock;

   i2c_byte_command_master_unit u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   status_scoreboard sb = new();

   // ---------------------------------------------------------------------------
   // predictor state: mirror of the master's line sequencer and write queue
   // ---------------------------------------------------------------------------
   logic [7:0]  pend_bytes [QueueDepth];
   int unsigned pend_count, flush_pos;
   int unsigned shifter, bit_cnt, delay_cnt, poll_cnt;
   int unsigned half_ticks = 500, stretch_max = 1000;
   phase_type   ph = PH_IDLE, ph_after_delay = PH_IDLE, ph_after_rise = PH_IDLE;
   kind_type    cmd_kind = K_START;
   bit          scl_lo, sda_lo, latched_fail, reply_nack;
   rsp_type     step_status;

   // stimulus knobs
   int  scl_low_pct = 0;     // chance of a stretched scl sample on a tick
   bit  force_flush_nack;    // answer nack on the ack of a flushed byte
   int  item_count;
   int  burst_left;
   int  hold_asks, hold_served, hold_left;
   int  pop_pct = 100;

   function automatic void go_delay(phase_type nxt);
      delay_cnt = 0;
      ph_after_delay = nxt;
      ph = PH_DELAY;
   endfunction

   // release scl and start polling it
   function automatic void go_rise(phase_type nxt);
      scl_lo = 0;
      poll_cnt = 0;
      ph_after_rise = nxt;
      ph = PH_WAIT;
   endfunction

   function automatic void finish_cmd(bit ack, logic [2:0] err);
      step_status.done_res = 1;
      step_status.acked = ack;
      step_status.error_kind = err;
      ph = PH_IDLE;
   endfunction

   // flush nack and timeout release both lines, empty the queue and stick
   function automatic void fail_cmd(logic [2:0] err);
      latched_fail = 1;
      scl_lo = 0;
      sda_lo = 0;
      pend_count = 0;
      flush_pos = 0;
      finish_cmd(0, err);
   endfunction

   // one accepted item in, one expected result out
   function automatic rsp_type master_step(req_type it);
      rsp_type     r;
      int unsigned d_lim, s_lim;
      step_status = '0;
      d_lim = (half_ticks == 0) ? 1 : half_ticks;
      s_lim = (stretch_max == 0) ? 1 : stretch_max;
      if (it.req_type) begin
         case (ph)
            PH_IDLE: ;
            PH_DELAY: begin
               delay_cnt++;
               if (delay_cnt >= d_lim) ph = ph_after_delay;
            end
            PH_WAIT: begin
               if (it.scl_level) go_delay(ph_after_rise);
               else begin
                  poll_cnt++;
                  if (poll_cnt >= s_lim) fail_cmd(ERR_TIMEOUT);
                  else go_delay(PH_WAIT);
               end
            end
            PH_START_REL: begin
               scl_lo = 0;
               sda_lo = 0;
               go_rise(PH_START_SDA);
            end
            PH_START_SDA: begin
               sda_lo = 1;
               go_delay(PH_START_SCL);
            end
            PH_START_SCL: begin
               scl_lo = 1;
               bit_cnt = 0;
               ph = PH_WB_BIT;
            end
            PH_WB_BIT: begin
               sda_lo = (shifter & 8'h80) == 0;
               go_delay(PH_WB_RISE);
            end
            PH_WB_RISE: go_rise(PH_WB_FALL);
            PH_WB_FALL: begin
               scl_lo = 1;
               shifter = (shifter << 1) & 8'hff;
               bit_cnt++;
               ph = (bit_cnt >= 8) ? PH_WB_ACKREL : PH_WB_BIT;
            end
            PH_WB_ACKREL: begin
               sda_lo = 0;
               go_delay(PH_WB_ACKRISE);
            end
            PH_WB_ACKRISE: go_rise(PH_WB_ACKSAMP);
            PH_WB_ACKSAMP: begin
               scl_lo = 1;
               if (cmd_kind == K_START) finish_cmd(!it.sda_level, ERR_NONE);
               else if (it.sda_level) fail_cmd(ERR_NACK);
               else ph = PH_FLUSH;
            end
            PH_FLUSH: begin
               if (flush_pos < pend_count) begin
                  shifter = pend_bytes[flush_pos];
                  flush_pos++;
                  bit_cnt = 0;
                  ph = PH_WB_BIT;
               end else begin
                  pend_count = 0;
                  flush_pos = 0;
                  ph = (cmd_kind == K_STOP) ? PH_STOP_SCL : PH_RB_REL;
               end
            end
            PH_STOP_SCL: begin
               scl_lo = 1;
               ph = PH_STOP_SDA;
            end
            PH_STOP_SDA: begin
               sda_lo = 1;
               go_delay(PH_STOP_RISE);
            end
            PH_STOP_RISE: go_rise(PH_STOP_END);
            PH_STOP_END: begin
               sda_lo = 0;
               finish_cmd(1, ERR_NONE);
            end
            PH_RB_REL: begin
               sda_lo = 0;
               shifter = 0;
               bit_cnt = 0;
               go_delay(PH_RB_RISE);
            end
            PH_RB_RISE: go_rise(PH_RB_SAMP);
            PH_RB_SAMP: begin
               shifter = ((shifter << 1) | it.sda_level) & 8'hff;
               scl_lo = 1;
               bit_cnt++;
               if (bit_cnt >= 8) ph = PH_RB_ACK;
               else go_delay(PH_RB_RISE);
            end
            PH_RB_ACK: begin
               sda_lo = !reply_nack;
               go_delay(PH_RB_ACKRISE);
            end
            PH_RB_ACKRISE: go_rise(PH_RB_END);
            PH_RB_END: begin
               scl_lo = 1;
               step_status.read_data = shifter[7:0];
               finish_cmd(1, ERR_NONE);
            end
            default: ph = PH_IDLE;
         endcase
      end else if (ph == PH_IDLE) begin
         // priority: latched failure, then start, stop, write, read
         if (latched_fail) finish_cmd(0, ERR_FAILED);
         else if (it.do_start) begin
            cmd_kind = K_START;
            shifter = it.data_byte;
            ph = PH_START_REL;
         end else if (it.do_stop) begin
            cmd_kind = K_STOP;
            flush_pos = 0;
            ph = PH_FLUSH;
         end else if (it.do_write) begin
            if (pend_count >= QueueDepth) finish_cmd(0, ERR_FULL);
            else begin
               pend_bytes[pend_count] = it.data_byte;
               pend_count++;
               finish_cmd(1, ERR_NONE);
            end
         end else if (it.do_read) begin
            cmd_kind = K_READ;
            reply_nack = it.send_nack;
            flush_pos = 0;
            ph = PH_FLUSH;
         end else finish_cmd(0, ERR_EMPTY);
      end
      r = step_status;
      r.scl_pull_low = scl_lo;
      r.sda_pull_low = sda_lo;
      r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // sender: bursts with random gaps; the item is accepted when push and not full
   // ---------------------------------------------------------------------------
   task automatic send_item(req_type it);
      if (burst_left == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 30);
      end
      burst_left--;
      req_push <= 1;
      req_item <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_item(master_step(it));
      item_count++;
   endtask

   // drop push and let every expected result drain, plus a little slack
   task automatic drain_all();
      req_push <= 0;
      while (sb.waiting_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ticks carry random pin levels; flushed-byte acks follow force_flush_nack
   function automatic req_type make_tick();
      req_type t;
      t = req_type'($urandom);
      t.req_type = 1;
      t.scl_level = ($urandom_range(0, 99) >= scl_low_pct);
      if (ph == PH_WB_ACKSAMP && cmd_kind != K_START) t.sda_level = force_flush_nack;
      return t;
   endfunction

   function automatic req_type rand_command();
      req_type c;
      int      pick;
      c = req_type'($urandom);
      c.req_type = 0;
      pick = $urandom_range(0, 99);
      if (pick < 88) {c.do_start, c.do_stop, c.do_write, c.do_read} = '0;
      if (pick < 25) c.do_write = 1;
      else if (pick < 45) c.do_read = 1;
      else if (pick < 60) c.do_stop = 1;
      else if (pick < 80) c.do_start = 1;
      return c;
   endfunction

   function automatic req_type cmd_item(bit st, bit sp, bit wr, bit rd, bit nk,
                                        logic [7:0] b);
      req_type c;
      c = req_type'($urandom);
      c.req_type = 0;
      {c.do_start, c.do_stop, c.do_write, c.do_read, c.send_nack} = {st, sp, wr, rd, nk};
      c.data_byte = b;
      return c;
   endfunction

   // one command, then ticks until the master is idle again; stray commands
   // while busy must be ignored
   task automatic run_command(req_type c);
      req_type n;
      send_item(c);
      while (ph != PH_IDLE) begin
         if ($urandom_range(0, 24) == 0) begin
            n = rand_command();
            send_item(n);
         end else send_item(make_tick());
      end
      if ($urandom_range(0, 3) == 0) send_item(make_tick());
   endtask

   // ---------------------------------------------------------------------------
   // register access: setup then access cycle, then read back
   // ---------------------------------------------------------------------------
   task automatic csr_cycle(bit wr, logic [0:0] idx, logic [31:0] val, output logic [31:0] rd);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= wr;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      rd = csr_prdata;
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   task automatic set_reg(logic [0:0] idx, logic [15:0] val);
      logic [31:0] rd;
      drain_all();
      csr_cycle(1, idx, {16'd0, val}, rd);
      csr_cycle(0, idx, '0, rd);
      if (rd != {16'd0, val}) begin
         $display("%0t: register %0d readback, expected %0d, actual %0d",
                  $realtime, idx, val, rd);
         sb.fail_count++;
      end
      if (idx == REG_HALF) half_ticks = val;
      else stretch_max = val;
   endtask

   // ---------------------------------------------------------------------------
   // receiver: pop on a changing duty pattern, long holds on request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_item);
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = 300;
         end
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
               0: pop_pct = 100;
               1: pop_pct = 60;
               default: pop_pct = 20;
            endcase
         end
         if (hold_left > 0) hold_left--;
         rsp_pop <= (hold_left == 0) && ($urandom_range(0, 99) < pop_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int fill_n;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: reset settings, immediate commands only
      run_command(cmd_item(0, 0, 0, 0, 0, 8'h00));        // empty command
      run_command(cmd_item(0, 0, 1, 0, 0, 8'h00));
      run_command(cmd_item(0, 0, 1, 0, 1, 8'hff));
      send_item(make_tick());                             // tick while idle

      // register extremes: zero acts as one, full scale read back
      set_reg(REG_HALF, 16'hffff);
      set_reg(REG_STRETCH, 16'hffff);
      run_command(cmd_item(0, 0, 1, 0, 0, 8'ha5));
      set_reg(REG_HALF, 16'd0);
      set_reg(REG_STRETCH, 16'd0);                       // any low poll would time out
      run_command(cmd_item(1, 0, 0, 0, 0, 8'h00));
      run_command(cmd_item(1, 0, 0, 0, 0, 8'hff));
      run_command(cmd_item(0, 1, 0, 0, 0, 8'h3c));       // stop flushes the queue
      run_command(cmd_item(0, 0, 0, 1, 1, 8'h00));       // read with nack
      run_command(cmd_item(0, 0, 1, 0, 0, 8'h81));
      run_command(cmd_item(0, 0, 0, 1, 0, 8'h00));       // flush then read with ack
      run_command(cmd_item(1, 1, 1, 1, 1, 8'hc3));       // all bits: start wins
      run_command(cmd_item(0, 1, 1, 1, 0, 8'h18));       // stop beats write and read

      // random part with clock stretching; the queue fill below adds about a thousand more
      set_reg(REG_HALF, 16'd1);
      set_reg(REG_STRETCH, 16'd16);
      scl_low_pct = 15;
      while (item_count < 700) begin
         if (item_count > 400 && hold_asks == 0) hold_asks++;
         if ($urandom_range(0, 39) == 0) begin
            drain_all();  // sender pause until all results are in
            set_reg(REG_HALF, 16'($urandom_range(1, 4)));
            set_reg(REG_STRETCH, 16'($urandom_range(12, 60)));
            scl_low_pct = $urandom_range(0, 20);
         end
         run_command(rand_command());
      end

      // fill the queue to its limit, overflow once, then end in a latched failure
      fill_n = QueueDepth - pend_count;
      for (int i = 0; i <= fill_n; i++) run_command(cmd_item(0, 0, 1, 0, 0, 8'($urandom)));
      if ($urandom_range(0, 1) == 0) begin
         force_flush_nack = 1;
      end else begin
         set_reg(REG_STRETCH, 16'd2);
         scl_low_pct = 100;
      end
      run_command(cmd_item(0, 1, 0, 0, 0, 8'h00));
      for (int i = 0; i < 6; i++) run_command(rand_command());

      drain_all();
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

[sim.f]
src/i2cbcm_pkg.sv
src/i2cbcm_fifo.sv
src/i2cbcm_engine.sv
src/i2c_byte_command_master_unit.sv
tb/testbench.sv
